@@ hw/rtl/df17fb_pkg.sv @@
// Shared types, constants and helper functions for the DF17 position frame builder.
package df17fb_pkg;

  // Frame geometry.
  localparam int unsigned DataBits    = 88;
  localparam int unsigned CrcBits     = 24;
  localparam int unsigned FrameBits   = DataBits + CrcBits;
  localparam int unsigned FrameBytes  = 30;
  localparam int unsigned ByteIdxW    = $clog2(FrameBytes);

  // Parity is computed one byte of data per cycle.
  localparam int unsigned CrcChunk    = 8;
  localparam int unsigned CrcSteps    = DataBits / CrcChunk;
  localparam int unsigned ChunkIdxW   = $clog2(CrcSteps);

  // Default depth of the frame queue between front and back.
  localparam int unsigned QueueDepthDefault = 2;

  // Mode S parity generator (x^24 term implied).
  localparam logic [CrcBits-1:0] CrcPoly = 24'hFFF409;

  // Altitude coding: code = (alt + 1000) / 25, division by reciprocal multiply.
  // 83887 = ceil(2^21 / 25) is exact for all sums up to 51000.
  localparam logic [15:0] AltMax    = 16'd50000;
  localparam logic [15:0] AltOffset = 16'd1000;
  localparam logic [16:0] AltRecip  = 17'd83887;
  localparam int unsigned AltShift  = 21;
  localparam int unsigned AltCodeW  = 11;

  // Fixed frame fields.
  localparam logic [7:0]  Df17Byte  = 8'h8D;
  localparam logic [19:0] MeHeader  = 20'h58000;
  localparam logic [7:0]  Preamble0 = 8'hA1;
  localparam logic [7:0]  Preamble1 = 8'h40;

  typedef logic [FrameBits-1:0] frame_t;

  // Advance the parity register over one byte of data, MSB first.
  function automatic logic [CrcBits-1:0] crc_chunk(input logic [CrcBits-1:0] crc,
                                                   input logic [CrcChunk-1:0] bits);
    logic [CrcBits-1:0] c;
    logic               fb;
    c = crc;
    for (int i = CrcChunk - 1; i >= 0; i--) begin
      fb = c[CrcBits-1] ^ bits[i];
      c  = {c[CrcBits-2:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  // Manchester code of one nibble, MSB first: a one becomes 10, a zero becomes 01.
  function automatic logic [7:0] manchester(input logic [3:0] nib);
    logic [7:0] m;
    m = '0;
    for (int b = 0; b < 4; b++) begin
      m[2*b+1] = nib[b];
      m[2*b]   = ~nib[b];
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/df17_position_frame_builder.sv @@
// A report passes the front end, the frame queue and the byte sender's output register before its first beat.
// Each report yields 30 beats, sent at one beat a cycle while the receiver is ready; the byte sender,
// not the parity unit, sets the sustained report rate.
// Reports queue ahead of the sender, so the front end takes the next one while a frame drains.
// Reset (asynchronous, active low) empties the queue and idles both ends; no clearing pass.
module df17_position_frame_builder import df17fb_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [23:0] icao_address_i,
  input  logic [15:0] altitude_ft_i,
  input  logic [16:0] cpr_lat_i,
  input  logic [16:0] cpr_lon_i,
  input  logic        odd_frame_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_byte_o
);

  logic   fr_valid, fr_ready;
  frame_t fr_data;
  logic   q_valid, q_ready;
  frame_t q_data;

  // Report intake, altitude coding and parity.
  df17fb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .icao_address_i (icao_address_i),
    .altitude_ft_i  (altitude_ft_i),
    .cpr_lat_i      (cpr_lat_i),
    .cpr_lon_i      (cpr_lon_i),
    .odd_frame_i    (odd_frame_i),
    .frame_valid_o  (fr_valid),
    .frame_ready_i  (fr_ready),
    .frame_o        (fr_data)
  );

  // Frame queue.
  df17fb_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  (fr_data),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_data)
  );

  // Byte sender.
  df17fb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (q_valid),
    .frame_ready_o (q_ready),
    .frame_i       (q_data),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_byte_o   (last_byte_o)
  );

endmodule

@@ hw/rtl/df17fb_front.sv @@
// Front end: accepts a position report, codes the altitude and computes the frame parity.
module df17fb_front import df17fb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [23:0] icao_address_i,
  input  logic [15:0] altitude_ft_i,
  input  logic [16:0] cpr_lat_i,
  input  logic [16:0] cpr_lon_i,
  input  logic        odd_frame_i,
  output logic        frame_valid_o,
  input  logic        frame_ready_i,
  output frame_t      frame_o
);

  typedef enum logic [2:0] {
    FeIdle,
    FeMul,
    FeBuild,
    FeCrc,
    FePush
  } fe_state_e;

  fe_state_e               state_q, state_d;
  logic [23:0]             icao_q;
  logic [16:0]             lat_q;
  logic [16:0]             lon_q;
  logic                    odd_q;
  logic [15:0]             alt_sum_q, alt_sum_d;
  logic [31:0]             prod_q;
  logic [DataBits-1:0]     data_q, shift_q;
  logic [CrcBits-1:0]      crc_q;
  logic [ChunkIdxW-1:0]    chunk_q;
  logic [AltCodeW-1:0]     alt_code;
  logic [19:0]             me_word;
  logic [DataBits-1:0]     data_build;
  logic                    in_accept;
  logic                    push;

  // A new report is taken when idle or in the same cycle the finished frame is queued.
  assign push       = (state_q == FePush) && frame_ready_i;
  assign in_ready_o = (state_q == FeIdle) || push;
  assign in_accept  = in_valid_i && in_ready_o;

  // Saturate the altitude and add the code offset.
  assign alt_sum_d = ((altitude_ft_i > AltMax) ? AltMax : altitude_ft_i) + AltOffset;

  // Assemble the 88 data bits from the registered product.
  assign alt_code   = prod_q[AltShift +: AltCodeW];
  assign me_word    = MeHeader | {8'b0, alt_code[10:4], 1'b1, alt_code[3:0]};
  assign data_build = {Df17Byte, icao_q, me_word, 1'b0, odd_q, lat_q, lon_q};

  // Sequencer: multiply, build, eight parity bits per cycle, then hand off.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FeIdle;
      chunk_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == FeCrc) begin
        chunk_q <= chunk_q + 1'b1;
      end else begin
        chunk_q <= '0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FeIdle:  if (in_accept) state_d = FeMul;
      FeMul:   state_d = FeBuild;
      FeBuild: state_d = FeCrc;
      FeCrc:   if (chunk_q == ChunkIdxW'(CrcSteps - 1)) state_d = FePush;
      FePush: begin
        if (push) begin
          state_d = in_accept ? FeMul : FeIdle;
        end
      end
      default: state_d = FeIdle;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      icao_q    <= icao_address_i;
      lat_q     <= cpr_lat_i;
      lon_q     <= cpr_lon_i;
      odd_q     <= odd_frame_i;
      alt_sum_q <= alt_sum_d;
    end
    if (state_q == FeMul) begin
      prod_q <= 32'(alt_sum_q) * 32'(AltRecip);
    end
    if (state_q == FeBuild) begin
      data_q  <= data_build;
      shift_q <= data_build;
      crc_q   <= '0;
    end
    if (state_q == FeCrc) begin
      crc_q   <= crc_chunk(crc_q, shift_q[DataBits-1 -: CrcChunk]);
      shift_q <= {shift_q[DataBits-CrcChunk-1:0], {CrcChunk{1'b0}}};
    end
  end

  assign frame_valid_o = (state_q == FePush);
  assign frame_o       = {data_q, crc_q};

endmodule

@@ hw/rtl/df17fb_fifo.sv @@
// Short frame queue between the front end and the byte sender.
module df17fb_fifo import df17fb_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_valid_i,
  output logic   wr_ready_o,
  input  frame_t wr_data_i,
  output logic   rd_valid_o,
  input  logic   rd_ready_i,
  output frame_t rd_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  frame_t            entries_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              wr_en, rd_en;

  assign wr_ready_o = (count_q != CntW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;
  assign rd_data_o  = entries_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_q <= count_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entries_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ hw/rtl/df17fb_back.sv @@
// Back end: sends the preamble and Manchester-coded nibbles, one beat a cycle unless stalled.
module df17fb_back import df17fb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       frame_valid_i,
  output logic       frame_ready_o,
  input  frame_t     frame_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_byte_o
);

  localparam logic [ByteIdxW-1:0] LastIdx = ByteIdxW'(FrameBytes - 1);

  logic                active_q, active_d;
  logic [ByteIdxW-1:0] idx_q, idx_d;
  frame_t              frame_q, frame_d;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_byte_q, out_byte_d;
  logic                out_last_q, out_last_d;
  logic                advance;
  logic                emit;
  logic                fetch;
  logic [7:0]          cur_byte;

  // The output register can take a new beat when empty or being drained.
  assign advance       = !out_valid_q || out_ready_i;
  assign emit          = active_q && advance;
  assign fetch         = frame_valid_i && (!active_q || (emit && (idx_q == LastIdx)));
  assign frame_ready_o = fetch;

  // Byte for the current position: two preamble bytes, then nibbles MSB first.
  always_comb begin
    if (idx_q == '0) begin
      cur_byte = Preamble0;
    end else if (idx_q == ByteIdxW'(1)) begin
      cur_byte = Preamble1;
    end else begin
      cur_byte = manchester(frame_q[FrameBits-1 -: 4]);
    end
  end

  // Next-state logic for the sender and the output register.
  always_comb begin
    active_d    = active_q;
    idx_d       = idx_q;
    frame_d     = frame_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = cur_byte;
      out_last_d  = (idx_q == LastIdx);
      idx_d       = idx_q + 1'b1;
      if (idx_q >= ByteIdxW'(2)) begin
        frame_d = {frame_q[FrameBits-5:0], 4'b0};
      end
      if (idx_q == LastIdx) begin
        active_d = 1'b0;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (fetch) begin
      active_d = 1'b1;
      idx_d    = '0;
      frame_d  = frame_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q    <= frame_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_byte_o = out_last_q;

endmodule

@@ tb/sv/tb_df17_position_frame_builder.sv @@
// Self-checking testbench for the DF17 position frame builder: reports in, Manchester beats out.
module tb_df17_position_frame_builder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkHalf     = 5;
  localparam int ResetCycles = 9;
  localparam int RandomCount = 310;
  localparam int DrainCycles = 80;
  localparam int CycleLimit  = 500000;

  // Frame constants used by the expected-beat builder.
  localparam logic [7:0]  DfByte      = 8'h8D;
  localparam logic [7:0]  SyncByteA   = 8'hA1;
  localparam logic [7:0]  SyncByteB   = 8'h40;
  localparam logic [7:0]  TypeCode11  = 8'h58;
  localparam logic [23:0] ParityPoly  = 24'hFFF409;
  localparam logic [15:0] AltCeiling  = 16'd50000;
  localparam int          AltBias     = 1000;
  localparam int          AltQuantum  = 25;
  localparam int          NibblesOut  = 28;

  // Ready pattern for the receiver; a one lets a beat through.
  localparam logic [22:0] ReadyPattern = 23'b11011100101101110001101;

  typedef struct packed {
    logic [23:0] icao;
    logic [15:0] alt;
    logic [16:0] lat;
    logic [16:0] lon;
    logic        odd;
    logic        typed;
    logic [87:0] data;
  } report_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } beat_t;

  // Directed reports. Where typed is set, the data field holds the 88 frame bits ahead of
  // the parity, read straight off the frame layout; other rows go through the predictor.
  localparam int DirectedCount = 16;
  localparam report_t DirectedRows [DirectedCount] = '{
    '{24'h000000, 16'd0,     17'h00000, 17'h00000, 1'b0, 1'b1, 88'h8D000000580580_00000000},
    '{24'hFFFFFF, 16'd50000, 17'h1FFFF, 17'h1FFFF, 1'b1, 1'b1, 88'h8DFFFFFF58FF87_FFFFFFFF},
    '{24'h000000, 16'd65535, 17'h00000, 17'h00000, 1'b0, 1'b1, 88'h8D00000058FF80_00000000},
    '{24'h000000, 16'd50001, 17'h00000, 17'h00000, 1'b0, 1'b1, 88'h8D00000058FF80_00000000},
    '{24'h000000, 16'd24,    17'h00000, 17'h00000, 1'b0, 1'b1, 88'h8D000000580580_00000000},
    '{24'h000000, 16'd25,    17'h00000, 17'h00000, 1'b0, 1'b1, 88'h8D000000580590_00000000},
    '{24'h000000, 16'd0,     17'h00000, 17'h00000, 1'b1, 1'b1, 88'h8D000000580584_00000000},
    '{24'h000000, 16'd0,     17'h1FFFF, 17'h00000, 1'b0, 1'b1, 88'h8D000000580583_FFFE0000},
    '{24'h000000, 16'd0,     17'h00000, 17'h1FFFF, 1'b0, 1'b1, 88'h8D000000580580_0001FFFF},
    '{24'hFFFFFF, 16'd0,     17'h00000, 17'h00000, 1'b0, 1'b1, 88'h8DFFFFFF580580_00000000},
    '{24'h800001, 16'd32768, 17'h10000, 17'h00001, 1'b0, 1'b0, 88'h0},
    '{24'h3C5A96, 16'd37000, 17'h0B8C2, 17'h0D3A1, 1'b1, 1'b0, 88'h0},
    '{24'hABCDEF, 16'd1000,  17'h15555, 17'h0AAAA, 1'b0, 1'b0, 88'h0},
    '{24'h555555, 16'd21845, 17'h0AAAA, 17'h15555, 1'b1, 1'b0, 88'h0},
    '{24'h000001, 16'd49999, 17'h00001, 17'h1FFFE, 1'b0, 1'b0, 88'h0},
    '{24'hFFFFFE, 16'd49975, 17'h1FFFE, 17'h00001, 1'b1, 1'b0, 88'h0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [23:0] icao_address_i;
  logic [15:0] altitude_ft_i;
  logic [16:0] cpr_lat_i;
  logic [16:0] cpr_lon_i;
  logic        odd_frame_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;
  logic        last_byte_o;

  beat_t pending_beats[$];
  int    mismatch_count;
  int    beats_checked;
  int    reports_sent;
  int    cycle_count;
  int    burst_left;
  logic [9:0] stall_tick;

  df17_position_frame_builder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .icao_address_i (icao_address_i),
    .altitude_ft_i  (altitude_ft_i),
    .cpr_lat_i      (cpr_lat_i),
    .cpr_lon_i      (cpr_lon_i),
    .odd_frame_i    (odd_frame_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_byte_o    (last_byte_o)
  );

  // The 88 data bits of a position report: DF byte, address, ME word with altitude, then CPR.
  function automatic logic [87:0] frame_data(input report_t r);
    logic [15:0] alt_sat;
    logic [10:0] alt_code;
    logic [19:0] me_alt;
    logic [35:0] position;
    alt_sat  = (r.alt > AltCeiling) ? AltCeiling : r.alt;
    alt_code = 11'((32'(alt_sat) + AltBias) / AltQuantum);
    me_alt   = {TypeCode11, alt_code[10:4], 1'b1, alt_code[3:0]};
    // The time bit is always zero.
    position = {1'b0, r.odd, r.lat, r.lon};
    return {DfByte, r.icao, me_alt, position};
  endfunction

  // Mode S parity over the data bits, one bit at a time, MSB first, zero start.
  function automatic logic [23:0] mode_s_parity(input logic [87:0] data);
    logic [23:0] rem;
    logic        feed;
    rem = '0;
    for (int i = 87; i >= 0; i--) begin
      feed = rem[23] ^ data[i];
      rem  = {rem[22:0], 1'b0} ^ (feed ? ParityPoly : 24'h0);
    end
    return rem;
  endfunction

  // Manchester byte of one nibble: a one sends 10, a zero sends 01, MSB first.
  function automatic logic [7:0] manchester_byte(input logic [3:0] nib);
    logic [7:0] code;
    code = '0;
    for (int b = 3; b >= 0; b--) begin
      code = {code[5:0], nib[b], ~nib[b]};
    end
    return code;
  endfunction

  // Queue the thirty beats that one frame should produce.
  task automatic queue_frame_beats(input logic [87:0] data);
    logic [111:0] frame;
    frame = {data, mode_s_parity(data)};
    pending_beats.push_back('{SyncByteA, 1'b0});
    pending_beats.push_back('{SyncByteB, 1'b0});
    for (int k = 0; k < NibblesOut; k++) begin
      pending_beats.push_back('{manchester_byte(frame[111-4*k -: 4]), k == NibblesOut - 1});
    end
  endtask

  // Offer one report, idling first when a burst has run out, and predict it once accepted.
  task automatic send_report(input report_t r);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 40);
      burst_left = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    icao_address_i <= r.icao;
    altitude_ft_i  <= r.alt;
    cpr_lat_i      <= r.lat;
    cpr_lon_i      <= r.lon;
    odd_frame_i    <= r.odd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    reports_sent++;
    queue_frame_beats(r.typed ? r.data : frame_data(r));
  endtask

  // Clock.
  initial clk_i = 1'b0;
  always #ClkHalf clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d beats outstanding", cycle_count,
               pending_beats.size());
      $display("tb_df17_position_frame_builder: errors");
      $finish;
    end
  end

  // Receiver: stall-free stretches alternate with a fixed ready pattern.
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 10'd1;
    if (stall_tick[8]) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ReadyPattern[stall_tick % 23];
    end
  end

  // Compare every accepted beat with the oldest expected one.
  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_beats.size() == 0) begin
        mismatch_count++;
        $display("%0t: expected no beat, actual byte %h last %b", $time, out_byte_o,
                 last_byte_o);
      end else begin
        want = pending_beats.pop_front();
        beats_checked++;
        if (out_byte_o !== want.value) begin
          mismatch_count++;
          $display("%0t: out_byte expected %h actual %h", $time, want.value, out_byte_o);
        end
        if (last_byte_o !== want.last) begin
          mismatch_count++;
          $display("%0t: last_byte expected %b actual %b", $time, want.last, last_byte_o);
        end
      end
    end
  end

  // Stimulus: reset, the directed table, then random reports, then drain and report.
  initial begin
    report_t r;
    int      pick;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    out_ready_i    = 1'b0;
    icao_address_i = '0;
    altitude_ft_i  = '0;
    cpr_lat_i      = '0;
    cpr_lon_i      = '0;
    odd_frame_i    = 1'b0;
    stall_tick     = '0;
    cycle_count    = 0;
    mismatch_count = 0;
    beats_checked  = 0;
    reports_sent   = 0;
    burst_left     = 0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DirectedCount; i++) begin
      send_report(DirectedRows[i]);
    end

    // Random reports; a share of them probes saturation and the coding edges.
    for (int i = 0; i < RandomCount; i++) begin
      pick    = $urandom_range(0, 9);
      r       = '0;
      r.icao  = 24'($urandom);
      r.odd   = 1'($urandom);
      r.lat   = ($urandom_range(0, 7) == 0) ? {17{r.odd}} : 17'($urandom);
      r.lon   = ($urandom_range(0, 7) == 0) ? {17{~r.odd}} : 17'($urandom);
      case (pick)
        0: r.alt = 16'($urandom_range(50001, 65535));
        1: r.alt = 16'($urandom_range(0, 30));
        2: r.alt = 16'($urandom_range(49970, 50000));
        default: r.alt = 16'($urandom_range(0, 50000));
      endcase
      send_report(r);
    end
    in_valid_i <= 1'b0;

    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d position reports (%0d from the directed table), %0d beats compared.",
             reports_sent, DirectedCount, beats_checked);
    $display("Altitudes spanned zero, truncation steps, the ceiling and saturated values.");
    if (mismatch_count == 0) begin
      $display("tb_df17_position_frame_builder: clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("tb_df17_position_frame_builder: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/df17fb_pkg.sv
hw/rtl/df17fb_front.sv
hw/rtl/df17fb_fifo.sv
hw/rtl/df17fb_back.sv
hw/rtl/df17_position_frame_builder.sv
tb/sv/tb_df17_position_frame_builder.sv
